[sv/vqre_pkg.sv]
// ----------------------------------------------------------------------------
// vqre_pkg: shared types and constants of the virtqueue request engine
// Descriptor ids, field widths, result codes and the memory port words.
// ----------------------------------------------------------------------------
package vqre_pkg;

	localparam int unsigned DESC_COUNT  = 8;
	localparam int unsigned ID_W        = $clog2(DESC_COUNT);
	localparam int unsigned LINK_W      = $clog2(DESC_COUNT + 1);
	localparam int unsigned BLOCK_BYTES = 1024;

	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned BLK_W    = 32;
	localparam int unsigned LEN_W    = 11;
	localparam int unsigned SECTOR_W = 33;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned FLAGS_W  = 2;
	localparam int unsigned RIDX_W   = 16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam int unsigned SECTOR_SHIFT = $clog2(BLOCK_BYTES / 512);
	localparam int unsigned HDR_SHIFT    = 4;

	localparam logic [LEN_W-1:0] HDR_LEN    = LEN_W'(16);
	localparam logic [LEN_W-1:0] DATA_LEN   = LEN_W'(BLOCK_BYTES);
	localparam logic [LEN_W-1:0] STATUS_LEN = LEN_W'(1);

	localparam logic [LINK_W-1:0] CHAIN_LEN = LINK_W'(3);
	localparam logic [LINK_W-1:0] FREE_MAX  = LINK_W'(DESC_COUNT);
	localparam logic [1:0]        WALK_LAST = 2'd2;

	localparam logic [FLAGS_W-1:0] FLAG_NEXT  = 2'b01;
	localparam logic [FLAGS_W-1:0] FLAG_WRITE = 2'b10;

	localparam logic FUNC_SUBMIT   = 1'b0;
	localparam logic FUNC_COMPLETE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_BASE = 1'b1;

	localparam logic [KIND_W-1:0] KIND_DESC     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POST     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DONE     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SPURIOUS = 3'd4;

	typedef struct packed {
		logic              en;
		logic [ID_W-1:0]   addr;
		logic [LINK_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic            has_next;
		logic [ID_W-1:0] next;
	} chain_ent_t;

	typedef struct packed {
		logic            en;
		logic [ID_W-1:0] addr;
		chain_ent_t      ent;
	} chain_wr_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ID_W-1:0]     desc_index;
		logic [ADDR_W-1:0]   desc_addr;
		logic [LEN_W-1:0]    desc_length;
		logic [FLAGS_W-1:0]  desc_flags;
		logic [ID_W-1:0]     next_index;
		logic                request_type;
		logic [SECTOR_W-1:0] sector;
		logic [ID_W-1:0]     ring_slot;
		logic                last;
	} result_t;

endpackage

[sv/vqre_link_mem.sv]
// ----------------------------------------------------------------------------
// vqre_link_mem: free list link memory
// One write and one registered read per cycle; an entry never written
// since reset reads as its id plus one.
// ----------------------------------------------------------------------------
module vqre_link_mem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vqre_pkg::link_wr_t             wr,
	input  logic                           rd_en,
	input  logic [vqre_pkg::ID_W-1:0]      rd_addr,
	output logic [vqre_pkg::LINK_W-1:0]    rd_data
);

	logic [vqre_pkg::LINK_W-1:0] mem [vqre_pkg::DESC_COUNT];
	logic [vqre_pkg::DESC_COUNT-1:0] written_q;
	logic [vqre_pkg::LINK_W-1:0] mem_rd_q;
	logic [vqre_pkg::ID_W-1:0]   rd_addr_q;
	logic                        rd_written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr.en) begin
			written_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			mem_rd_q     <= mem[rd_addr];
			rd_addr_q    <= rd_addr;
			rd_written_q <= written_q[rd_addr];
		end
	end

	assign rd_data = rd_written_q ? mem_rd_q
		: vqre_pkg::LINK_W'(rd_addr_q) + vqre_pkg::LINK_W'(1);

endmodule

[sv/vqre_chain_mem.sv]
// ----------------------------------------------------------------------------
// vqre_chain_mem: descriptor chain memory
// Next link and has-next flag per descriptor; one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module vqre_chain_mem (
	input  logic                       clk,
	input  vqre_pkg::chain_wr_t        wr,
	input  logic                       rd_en,
	input  logic [vqre_pkg::ID_W-1:0]  rd_addr,
	output vqre_pkg::chain_ent_t       rd_data
);

	vqre_pkg::chain_ent_t mem [vqre_pkg::DESC_COUNT];
	vqre_pkg::chain_ent_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.ent;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[sv/virtqueue_request_engine_core.sv]
// ----------------------------------------------------------------------------
// virtqueue_request_engine_core: driver side of a split virtqueue
// Input words are either a block request submit or a device completion.
// A submit pops three descriptors from the free list and gives four result
// words: header, data and status descriptor writes, then the avail post.
// With fewer than three free descriptors it gives one reject word.
// A completion of a busy head walks the chain through the chain memory,
// pushes each descriptor back on the free list and gives one done word;
// a completion of an idle head gives one spurious word. The last word of
// every input has last set.
// Inputs are taken one at a time. A reject or spurious word is loaded in the
// dispatch step after accept, submit words in the pop and post steps that follow,
// a done word after a chain walk of up to three chain steps.
// The result register lets the next input in while a word waits; a stalled
// receiver holds the engine in any step that loads a word, with all state intact.
// Reset clears the free list to ids 0..7 in order, all busy marks, both
// ring indices and both base registers; it needs no clearing pass.
// Configuration writes take effect at once and are meant for idle times.
// ----------------------------------------------------------------------------
module virtqueue_request_engine_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [vqre_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vqre_pkg::ADDR_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic                                is_write,
	input  logic [vqre_pkg::BLK_W-1:0]          block_number,
	input  logic [vqre_pkg::ADDR_W-1:0]         buffer_address,
	input  logic [vqre_pkg::ID_W-1:0]           completed_head,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vqre_pkg::KIND_W-1:0]         kind,
	output logic [vqre_pkg::ID_W-1:0]           desc_index,
	output logic [vqre_pkg::ADDR_W-1:0]         desc_addr,
	output logic [vqre_pkg::LEN_W-1:0]          desc_length,
	output logic [vqre_pkg::FLAGS_W-1:0]        desc_flags,
	output logic [vqre_pkg::ID_W-1:0]           next_index,
	output logic                                request_type,
	output logic [vqre_pkg::SECTOR_W-1:0]       sector,
	output logic [vqre_pkg::ID_W-1:0]           ring_slot,
	output logic                                last
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_POP_B    = 3'd2;
	localparam logic [2:0] ST_POP_C    = 3'd3;
	localparam logic [2:0] ST_POP_T    = 3'd4;
	localparam logic [2:0] ST_POST     = 3'd5;
	localparam logic [2:0] ST_WALK     = 3'd6;
	localparam logic [2:0] ST_DONE     = 3'd7;

	logic [2:0] state_q, state_d;

	logic                                func_q;
	logic                                wr_q;
	logic [vqre_pkg::BLK_W-1:0]          blk_q;
	logic [vqre_pkg::ADDR_W-1:0]         buf_q;
	logic [vqre_pkg::ID_W-1:0]           head_q;

	logic [vqre_pkg::ID_W-1:0]   a_q, a_d, b_q, b_d, c_q, c_d, cur_q, cur_d;
	logic [1:0]                  walk_cnt_q, walk_cnt_d;
	logic [vqre_pkg::LINK_W-1:0] free_top_q, free_top_d;
	logic [vqre_pkg::LINK_W-1:0] free_count_q, free_count_d;
	logic [vqre_pkg::DESC_COUNT-1:0] busy_q, busy_d;
	logic [vqre_pkg::RIDX_W-1:0] avail_q, avail_d, used_q, used_d;
	logic [vqre_pkg::ADDR_W-1:0] header_base_q, status_base_q;

	logic              out_valid_q;
	vqre_pkg::result_t out_q, ld;
	logic              out_load, out_space, in_acc;

	vqre_pkg::link_wr_t          link_wr;
	logic                        link_rd_en;
	logic [vqre_pkg::ID_W-1:0]   link_rd_addr;
	logic [vqre_pkg::LINK_W-1:0] link_rd_data;

	vqre_pkg::chain_wr_t         chain_wr;
	logic                        chain_rd_en;
	logic [vqre_pkg::ID_W-1:0]   chain_rd_addr;
	vqre_pkg::chain_ent_t        chain_rd_data;

	vqre_link_mem u_link_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (link_wr),
		.rd_en   (link_rd_en),
		.rd_addr (link_rd_addr),
		.rd_data (link_rd_data)
	);

	vqre_chain_mem u_chain_mem (
		.clk     (clk),
		.wr      (chain_wr),
		.rd_en   (chain_rd_en),
		.rd_addr (chain_rd_addr),
		.rd_data (chain_rd_data)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_space = !out_valid_q || out_ready;

	always_comb begin
		state_d       = state_q;
		a_d           = a_q;
		b_d           = b_q;
		c_d           = c_q;
		cur_d         = cur_q;
		walk_cnt_d    = walk_cnt_q;
		free_top_d    = free_top_q;
		free_count_d  = free_count_q;
		busy_d        = busy_q;
		avail_d       = avail_q;
		used_d        = used_q;
		out_load      = 1'b0;
		ld            = '0;
		link_wr       = '0;
		link_rd_en    = 1'b0;
		link_rd_addr  = a_q;
		chain_wr      = '0;
		chain_rd_en   = 1'b0;
		chain_rd_addr = head_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (func_q == vqre_pkg::FUNC_SUBMIT) begin
					if (free_count_q < vqre_pkg::CHAIN_LEN) begin
						if (out_space) begin
							out_load = 1'b1;
							ld.kind  = vqre_pkg::KIND_REJECT;
							ld.last  = 1'b1;
							state_d  = ST_IDLE;
						end
					end else begin
						link_rd_en   = 1'b1;
						link_rd_addr = free_top_q[vqre_pkg::ID_W-1:0];
						a_d          = free_top_q[vqre_pkg::ID_W-1:0];
						state_d      = ST_POP_B;
					end
				end else if (busy_q[head_q]) begin
					busy_d[head_q] = 1'b0;
					chain_rd_en    = 1'b1;
					chain_rd_addr  = head_q;
					cur_d          = head_q;
					walk_cnt_d     = 2'd0;
					state_d        = ST_WALK;
				end else if (out_space) begin
					out_load      = 1'b1;
					ld.kind       = vqre_pkg::KIND_SPURIOUS;
					ld.desc_index = head_q;
					ld.ring_slot  = used_q[vqre_pkg::ID_W-1:0];
					ld.last       = 1'b1;
					used_d        = used_q + vqre_pkg::RIDX_W'(1);
					state_d       = ST_IDLE;
				end
			end
			ST_POP_B: begin
				if (out_space) begin
					b_d             = link_rd_data[vqre_pkg::ID_W-1:0];
					link_rd_en      = 1'b1;
					link_rd_addr    = link_rd_data[vqre_pkg::ID_W-1:0];
					chain_wr.en     = 1'b1;
					chain_wr.addr   = a_q;
					chain_wr.ent    = '{has_next: 1'b1,
						next: link_rd_data[vqre_pkg::ID_W-1:0]};
					out_load        = 1'b1;
					ld.kind         = vqre_pkg::KIND_DESC;
					ld.desc_index   = a_q;
					ld.desc_addr    = header_base_q
						+ (vqre_pkg::ADDR_W'(a_q) << vqre_pkg::HDR_SHIFT);
					ld.desc_length  = vqre_pkg::HDR_LEN;
					ld.desc_flags   = vqre_pkg::FLAG_NEXT;
					ld.next_index   = link_rd_data[vqre_pkg::ID_W-1:0];
					ld.request_type = wr_q;
					ld.sector       = vqre_pkg::SECTOR_W'(blk_q) << vqre_pkg::SECTOR_SHIFT;
					state_d         = ST_POP_C;
				end
			end
			ST_POP_C: begin
				if (out_space) begin
					c_d            = link_rd_data[vqre_pkg::ID_W-1:0];
					link_rd_en     = 1'b1;
					link_rd_addr   = link_rd_data[vqre_pkg::ID_W-1:0];
					chain_wr.en    = 1'b1;
					chain_wr.addr  = b_q;
					chain_wr.ent   = '{has_next: 1'b1,
						next: link_rd_data[vqre_pkg::ID_W-1:0]};
					out_load       = 1'b1;
					ld.kind        = vqre_pkg::KIND_DESC;
					ld.desc_index  = b_q;
					ld.desc_addr   = buf_q;
					ld.desc_length = vqre_pkg::DATA_LEN;
					ld.desc_flags  = wr_q ? vqre_pkg::FLAG_NEXT
						: (vqre_pkg::FLAG_NEXT | vqre_pkg::FLAG_WRITE);
					ld.next_index  = link_rd_data[vqre_pkg::ID_W-1:0];
					state_d        = ST_POP_T;
				end
			end
			ST_POP_T: begin
				if (out_space) begin
					free_top_d     = link_rd_data;
					free_count_d   = free_count_q - vqre_pkg::CHAIN_LEN;
					busy_d[a_q]    = 1'b1;
					chain_wr.en    = 1'b1;
					chain_wr.addr  = c_q;
					chain_wr.ent   = '0;
					out_load       = 1'b1;
					ld.kind        = vqre_pkg::KIND_DESC;
					ld.desc_index  = c_q;
					ld.desc_addr   = status_base_q + vqre_pkg::ADDR_W'(a_q);
					ld.desc_length = vqre_pkg::STATUS_LEN;
					ld.desc_flags  = vqre_pkg::FLAG_WRITE;
					state_d        = ST_POST;
				end
			end
			ST_POST: begin
				if (out_space) begin
					out_load      = 1'b1;
					ld.kind       = vqre_pkg::KIND_POST;
					ld.desc_index = a_q;
					ld.ring_slot  = avail_q[vqre_pkg::ID_W-1:0];
					ld.last       = 1'b1;
					avail_d       = avail_q + vqre_pkg::RIDX_W'(1);
					state_d       = ST_IDLE;
				end
			end
			ST_WALK: begin
				// push cur back on the free list
				link_wr.en   = 1'b1;
				link_wr.addr = cur_q;
				link_wr.data = free_top_q;
				free_top_d   = vqre_pkg::LINK_W'(cur_q);
				if (free_count_q < vqre_pkg::FREE_MAX) begin
					free_count_d = free_count_q + vqre_pkg::LINK_W'(1);
				end
				if (chain_rd_data.has_next && (walk_cnt_q != vqre_pkg::WALK_LAST)) begin
					cur_d         = chain_rd_data.next;
					walk_cnt_d    = walk_cnt_q + 2'd1;
					chain_rd_en   = 1'b1;
					chain_rd_addr = chain_rd_data.next;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_space) begin
					out_load      = 1'b1;
					ld.kind       = vqre_pkg::KIND_DONE;
					ld.desc_index = head_q;
					ld.ring_slot  = used_q[vqre_pkg::ID_W-1:0];
					ld.last       = 1'b1;
					used_d        = used_q + vqre_pkg::RIDX_W'(1);
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			walk_cnt_q    <= '0;
			free_top_q    <= '0;
			free_count_q  <= vqre_pkg::FREE_MAX;
			busy_q        <= '0;
			avail_q       <= '0;
			used_q        <= '0;
			header_base_q <= '0;
			status_base_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			walk_cnt_q   <= walk_cnt_d;
			free_top_q   <= free_top_d;
			free_count_q <= free_count_d;
			busy_q       <= busy_d;
			avail_q      <= avail_d;
			used_q       <= used_d;
			if (cfg_wr_en) begin
				if (cfg_index == vqre_pkg::CFG_HEADER_BASE) begin
					header_base_q <= cfg_data;
				end else if (cfg_index == vqre_pkg::CFG_STATUS_BASE) begin
					status_base_q <= cfg_data;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_q   <= a_d;
		b_q   <= b_d;
		c_q   <= c_d;
		cur_q <= cur_d;
		if (in_acc) begin
			func_q <= func;
			wr_q   <= is_write;
			blk_q  <= block_number;
			buf_q  <= buffer_address;
			head_q <= completed_head;
		end
		if (out_load) begin
			out_q <= ld;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign desc_index   = out_q.desc_index;
	assign desc_addr    = out_q.desc_addr;
	assign desc_length  = out_q.desc_length;
	assign desc_flags   = out_q.desc_flags;
	assign next_index   = out_q.next_index;
	assign request_type = out_q.request_type;
	assign sector       = out_q.sector;
	assign ring_slot    = out_q.ring_slot;
	assign last         = out_q.last;

	a_free_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= vqre_pkg::FREE_MAX)
		else $error("free count above descriptor count");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (walk_cnt_q <= vqre_pkg::WALK_LAST))
		else $error("chain walk beyond three descriptors");

	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_load)
		else $error("result word loaded while taking input");

	a_head_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_POP_T) && out_space) |=> busy_q[$past(a_q)])
		else $error("posted head not marked busy");

	a_used_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && ((ld.kind == vqre_pkg::KIND_DONE)
			|| (ld.kind == vqre_pkg::KIND_SPURIOUS)))
		|=> (used_q == $past(used_q) + vqre_pkg::RIDX_W'(1)))
		else $error("used index did not advance on completion");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: virtqueue request engine, block request submits and completions
// Drives submit and completion words through the input channel, keeps its own
// copy of the free list, busy heads, chain links and ring indices to predict
// every result word, and checks each word field by field in arrival order.
// Directed tests cover list exhaustion, spurious and repeated completions and
// wrapping base addresses; a random part follows, with gaps on both channels in some phases.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 12;

	logic                           clk            = 1'b0;
	logic                           arst_n         = 1'b0;
	logic                           cfg_wr_en      = 1'b0;
	logic [vqre_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
	logic [vqre_pkg::ADDR_W-1:0]    cfg_data       = '0;
	logic                           in_valid       = 1'b0;
	logic                           in_ready;
	logic                           func           = 1'b0;
	logic                           is_write       = 1'b0;
	logic [vqre_pkg::BLK_W-1:0]     block_number   = '0;
	logic [vqre_pkg::ADDR_W-1:0]    buffer_address = '0;
	logic [vqre_pkg::ID_W-1:0]      completed_head = '0;
	logic                           out_valid;
	logic                           out_ready      = 1'b0;
	logic [vqre_pkg::KIND_W-1:0]    kind;
	logic [vqre_pkg::ID_W-1:0]      desc_index;
	logic [vqre_pkg::ADDR_W-1:0]    desc_addr;
	logic [vqre_pkg::LEN_W-1:0]     desc_length;
	logic [vqre_pkg::FLAGS_W-1:0]   desc_flags;
	logic [vqre_pkg::ID_W-1:0]      next_index;
	logic                           request_type;
	logic [vqre_pkg::SECTOR_W-1:0]  sector;
	logic [vqre_pkg::ID_W-1:0]      ring_slot;
	logic                           last;

	// queue model
	logic [vqre_pkg::LINK_W-1:0] free_links [vqre_pkg::DESC_COUNT];
	logic [vqre_pkg::LINK_W-1:0] free_top;
	logic [vqre_pkg::LINK_W-1:0] free_count;
	logic                        head_busy  [vqre_pkg::DESC_COUNT];
	logic [vqre_pkg::ID_W-1:0]   chain_next [vqre_pkg::DESC_COUNT];
	logic                        chain_more [vqre_pkg::DESC_COUNT];
	logic [vqre_pkg::RIDX_W-1:0] avail_idx;
	logic [vqre_pkg::RIDX_W-1:0] used_ptr;
	logic [vqre_pkg::ADDR_W-1:0] hdr_base;
	logic [vqre_pkg::ADDR_W-1:0] stat_base;

	vqre_pkg::result_t due_words [$];
	int      mismatch_count = 0;
	int      cycle_count    = 0;
	bit      gaps_on        = 1'b0;

	virtqueue_request_engine_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.is_write(is_write),
		.block_number(block_number),
		.buffer_address(buffer_address),
		.completed_head(completed_head),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.desc_index(desc_index),
		.desc_addr(desc_addr),
		.desc_length(desc_length),
		.desc_flags(desc_flags),
		.next_index(next_index),
		.request_type(request_type),
		.sector(sector),
		.ring_slot(ring_slot),
		.last(last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void reset_model();
		for (int i = 0; i < vqre_pkg::DESC_COUNT; i++) begin
			free_links[i] = vqre_pkg::LINK_W'(i + 1);
			head_busy[i]  = 1'b0;
			chain_next[i] = '0;
			chain_more[i] = 1'b0;
		end
		free_top   = '0;
		free_count = vqre_pkg::FREE_MAX;
		avail_idx  = '0;
		used_ptr   = '0;
		hdr_base   = '0;
		stat_base  = '0;
	endfunction

	function automatic vqre_pkg::result_t make_word(logic [vqre_pkg::KIND_W-1:0] k,
			logic [vqre_pkg::ID_W-1:0] idx, logic [vqre_pkg::ADDR_W-1:0] addr,
			logic [vqre_pkg::LEN_W-1:0] len, logic [vqre_pkg::FLAGS_W-1:0] flags,
			logic [vqre_pkg::ID_W-1:0] nxt, logic rtype,
			logic [vqre_pkg::SECTOR_W-1:0] sec, logic [vqre_pkg::ID_W-1:0] slot,
			logic lst);
		vqre_pkg::result_t w;
		w.kind         = k;
		w.desc_index   = idx;
		w.desc_addr    = addr;
		w.desc_length  = len;
		w.desc_flags   = flags;
		w.next_index   = nxt;
		w.request_type = rtype;
		w.sector       = sec;
		w.ring_slot    = slot;
		w.last         = lst;
		return w;
	endfunction

	function automatic logic [vqre_pkg::ID_W-1:0] pop_free();
		logic [vqre_pkg::ID_W-1:0] id;
		id         = free_top[vqre_pkg::ID_W-1:0];
		free_top   = free_links[id];
		free_count = free_count - 1'b1;
		return id;
	endfunction

	function automatic void push_free(logic [vqre_pkg::ID_W-1:0] id);
		free_links[id] = free_top;
		free_top       = vqre_pkg::LINK_W'(id);
		if (free_count < vqre_pkg::FREE_MAX)
			free_count = free_count + 1'b1;
	endfunction

	function automatic void predict_words(logic f, logic wr,
			logic [vqre_pkg::BLK_W-1:0] blk, logic [vqre_pkg::ADDR_W-1:0] data_addr,
			logic [vqre_pkg::ID_W-1:0] head);
		logic [vqre_pkg::ID_W-1:0]     a, b, c, cur, nxt;
		logic                          more;
		logic [vqre_pkg::SECTOR_W-1:0] sec;
		logic [vqre_pkg::KIND_W-1:0]   outcome;
		logic [vqre_pkg::FLAGS_W-1:0]  data_flags;
		if (f == vqre_pkg::FUNC_SUBMIT) begin
			if (free_count < vqre_pkg::CHAIN_LEN) begin
				due_words.push_back(make_word(vqre_pkg::KIND_REJECT, '0, '0, '0, '0, '0,
					1'b0, '0, '0, 1'b1));
				return;
			end
			a = pop_free();
			b = pop_free();
			c = pop_free();
			sec = {1'b0, blk} * (vqre_pkg::BLOCK_BYTES / 512);
			chain_next[a] = b;
			chain_more[a] = 1'b1;
			chain_next[b] = c;
			chain_more[b] = 1'b1;
			chain_next[c] = '0;
			chain_more[c] = 1'b0;
			head_busy[a]  = 1'b1;
			data_flags = wr ? vqre_pkg::FLAG_NEXT
				: (vqre_pkg::FLAG_NEXT | vqre_pkg::FLAG_WRITE);
			due_words.push_back(make_word(vqre_pkg::KIND_DESC, a,
				hdr_base + (vqre_pkg::ADDR_W'(a) << 4), vqre_pkg::HDR_LEN,
				vqre_pkg::FLAG_NEXT, b, wr, sec, '0, 1'b0));
			due_words.push_back(make_word(vqre_pkg::KIND_DESC, b, data_addr,
				vqre_pkg::DATA_LEN, data_flags, c, 1'b0, '0, '0, 1'b0));
			due_words.push_back(make_word(vqre_pkg::KIND_DESC, c,
				stat_base + vqre_pkg::ADDR_W'(a), vqre_pkg::STATUS_LEN,
				vqre_pkg::FLAG_WRITE, '0, 1'b0, '0, '0, 1'b0));
			due_words.push_back(make_word(vqre_pkg::KIND_POST, a, '0, '0, '0, '0, 1'b0, '0,
				avail_idx[vqre_pkg::ID_W-1:0], 1'b1));
			avail_idx = avail_idx + 1'b1;
		end else begin
			outcome = vqre_pkg::KIND_SPURIOUS;
			if (head_busy[head]) begin
				head_busy[head] = 1'b0;
				cur = head;
				for (int n = 0; n < 3; n++) begin
					more = chain_more[cur];
					nxt  = chain_next[cur];
					push_free(cur);
					if (!more)
						break;
					cur = nxt;
				end
				outcome = vqre_pkg::KIND_DONE;
			end
			due_words.push_back(make_word(outcome, head, '0, '0, '0, '0, 1'b0, '0,
				used_ptr[vqre_pkg::ID_W-1:0], 1'b1));
			used_ptr = used_ptr + 1'b1;
		end
	endfunction

	task automatic send_word(input logic f, input logic wr,
			input logic [vqre_pkg::BLK_W-1:0] blk,
			input logic [vqre_pkg::ADDR_W-1:0] data_addr,
			input logic [vqre_pkg::ID_W-1:0] head);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		func           <= f;
		is_write       <= wr;
		block_number   <= blk;
		buffer_address <= data_addr;
		completed_head <= head;
		do @(posedge clk); while (!in_ready);
		predict_words(f, wr, blk, data_addr, head);
	endtask

	task automatic send_submit(input logic wr, input logic [vqre_pkg::BLK_W-1:0] blk,
			input logic [vqre_pkg::ADDR_W-1:0] data_addr);
		send_word(vqre_pkg::FUNC_SUBMIT, wr, blk, data_addr, vqre_pkg::ID_W'($urandom));
	endtask

	task automatic send_completion(input logic [vqre_pkg::ID_W-1:0] head);
		send_word(vqre_pkg::FUNC_COMPLETE, 1'($urandom), $urandom, {$urandom, $urandom},
			head);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [vqre_pkg::CFG_IDX_W-1:0] idx,
			input logic [vqre_pkg::ADDR_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == vqre_pkg::CFG_HEADER_BASE)
			hdr_base = value;
		else
			stat_base = value;
	endtask

	task automatic complete_all_busy();
		for (int i = 0; i < vqre_pkg::DESC_COUNT; i++)
			if (head_busy[i])
				send_completion(vqre_pkg::ID_W'(i));
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_watch
		vqre_pkg::result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (due_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result word, kind %0d", $realtime, kind);
			end else begin
				w = due_words.pop_front();
				check_field("kind", 64'(w.kind), 64'(kind));
				check_field("desc_index", 64'(w.desc_index), 64'(desc_index));
				check_field("desc_addr", w.desc_addr, desc_addr);
				check_field("desc_length", 64'(w.desc_length), 64'(desc_length));
				check_field("desc_flags", 64'(w.desc_flags), 64'(desc_flags));
				check_field("next_index", 64'(w.next_index), 64'(next_index));
				check_field("request_type", 64'(w.request_type), 64'(request_type));
				check_field("sector", 64'(w.sector), 64'(sector));
				check_field("ring_slot", 64'(w.ring_slot), 64'(ring_slot));
				check_field("last", 64'(w.last), 64'(last));
			end
		end
	end

	initial begin : ready_driver
		int hold;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 19);
				out_ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// use up the free list, then one submit too many
	task automatic test_fill_and_reject();
		send_submit(1'b0, '0, '0);
		send_submit(1'b1, '1, '1);
		send_submit(1'b1, 32'h1234_5678, 64'h0123_4567_89ab_cdef);
		drain_results();
	endtask

	// spurious heads, repeated completion, reuse of freed descriptors
	task automatic test_completions();
		send_completion(3'd7);
		send_completion(3'd3);
		send_completion(3'd3);
		send_submit(1'b1, 32'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		send_submit(1'b0, 32'haaaa_aaaa, 64'h5555_5555_5555_5555);
		complete_all_busy();
		send_completion(3'd0);
		drain_results();
	endtask

	// base registers at their extremes, addresses wrap at 64 bits
	task automatic test_address_extremes();
		write_reg(vqre_pkg::CFG_HEADER_BASE, '1);
		write_reg(vqre_pkg::CFG_STATUS_BASE, '1);
		send_submit(1'b0, '1, '1);
		send_submit(1'b1, '0, '0);
		complete_all_busy();
		drain_results();
		write_reg(vqre_pkg::CFG_HEADER_BASE, 64'hffff_ffff_ffff_fff0);
		write_reg(vqre_pkg::CFG_STATUS_BASE, 64'h8000_0000_0000_0000);
		send_submit(1'b1, 32'h8000_0001, 64'h8000_0000_0000_0001);
		complete_all_busy();
		drain_results();
	endtask

	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [vqre_pkg::ID_W-1:0]  busy_ids [$];
		int                         pick;
		logic [vqre_pkg::BLK_W-1:0] blk;
		for (int p = 0; p < phases; p++) begin
			write_reg(vqre_pkg::CFG_HEADER_BASE, {$urandom, $urandom});
			write_reg(vqre_pkg::CFG_STATUS_BASE, {$urandom, $urandom});
			gaps_on = (p % 2 == 0) && (p != phases - 1);
			for (int n = 0; n < per_phase; n++) begin
				busy_ids.delete();
				for (int i = 0; i < vqre_pkg::DESC_COUNT; i++)
					if (head_busy[i])
						busy_ids.push_back(vqre_pkg::ID_W'(i));
				pick = $urandom_range(0, 9);
				blk = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
				if (pick == 9)
					send_completion(vqre_pkg::ID_W'($urandom));
				else if (pick < 5 || busy_ids.size() == 0)
					send_submit(1'($urandom), blk, {$urandom, $urandom});
				else
					send_completion(busy_ids[$urandom_range(0, busy_ids.size() - 1)]);
				if ($urandom_range(0, 29) == 0)
					drain_results();
			end
			complete_all_busy();
			drain_results();
		end
	endtask

	initial begin
		reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		gaps_on = 1'b1;
		test_fill_and_reject();
		test_completions();
		test_address_extremes();
		test_random_traffic(4, 40);
		drain_results();
		if (mismatch_count == 0 && due_words.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
